// ----- src/two_party_lock_table_assert.svh -----
// Assertion macros for the lock table.
`ifndef TWO_PARTY_LOCK_TABLE_ASSERT_SVH
`define TWO_PARTY_LOCK_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TPLT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define TPLT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPLT_ASSERT(name, clk, rst, prop, msg)
`define TPLT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ----- src/tplt_pkg.sv -----
package tplt_pkg;

   // request function codes
   localparam logic [2:0] FN_CREATE  = 3'd0;
   localparam logic [2:0] FN_ACQUIRE = 3'd1;
   localparam logic [2:0] FN_RELEASE = 3'd2;
   localparam logic [2:0] FN_DESTROY = 3'd3;
   localparam logic [2:0] FN_POLL    = 3'd4;

   // free-slot search group size
   localparam int GRP_SIZE = 16;
   localparam int GRP_W    = 4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_HELD     = 3'd3,
      ST_NOT_HELD = 3'd4,
      ST_WAIT     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_ACQUIRE = 3'd1,
      OP_RELEASE = 3'd2,
      OP_DESTROY = 3'd3,
      OP_POLL    = 3'd4,
      OP_BAD     = 3'd5
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] idx;
      logic       role;
   } item_type;

   typedef struct packed {
      logic idle;
      logic exec;
   } back_status_type;

endpackage

// ----- src/two_party_lock_table.sv -----
// A request goes through the queue and the back end's read and execute states
// to the response register. The back end takes no new item until the last has
// had its read-then-execute pass over lock memory and two-level free-slot search.
// Reset: synchronous, active high; clears all in-use bits, the queue and the
// response valid bit. Flag memory needs no sweep, since create rewrites an entry.
`include "two_party_lock_table_assert.svh"

module two_party_lock_table #(
   parameter int NUM_LOCKS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_func,
   input  logic [7:0] req_lock_id,
   input  logic       req_role,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_lock_index
);
   import tplt_pkg::*;

   // front to back queue signals
   logic            q_push, q_full, q_pop, q_empty;
   item_type        push_item, pop_item;
   back_status_type back_status;

   // Front: accept items while the queue has room and classify them (function decode, id range check).
   tplt_front #(
      .NUM_LOCKS (NUM_LOCKS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_lock_id (req_lock_id),
      .req_role    (req_role),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   // Hold classified items so the front keeps taking requests while the back
   // end waits on a stalled response.
   tplt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   // Back: read the entry, run the lock scheme, write back and drive the
   // response register.
   tplt_back #(
      .NUM_LOCKS (NUM_LOCKS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_lock_index (rsp_lock_index),
      .back_status    (back_status)
   );

   // Only a successful create returns a nonzero index.
   `TPLT_ASSERT(a_index_only_ok, clock, reset, rsp_valid && (rsp_status != ST_OK) |-> rsp_lock_index == 6'd0, "lock index on failed request")
   // Status codes stay within the defined set.
   `TPLT_ASSERT(a_status_range, clock, reset, rsp_valid |-> rsp_status <= ST_WAIT, "undefined status code")
   // A new response appears only right after the back end executed an item.
   `TPLT_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid) |-> $past(back_status.exec), "response without execution")
   // Never pop an empty queue.
   `TPLT_ASSERT_ALWAYS(a_no_pop_empty, clock, q_pop |-> !q_empty, "pop from empty queue")

endmodule

// ----- src/tplt_front.sv -----
module tplt_front #(
   parameter int NUM_LOCKS = 64
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [7:0]        req_lock_id,
   input  logic              req_role,
   input  logic              q_full,
   output logic              q_push,
   output tplt_pkg::item_type q_item
);
   import tplt_pkg::*;

   localparam logic [8:0] LOCKS_LIM = 9'(NUM_LOCKS);

   logic id_ok;

   assign id_ok     = {1'b0, req_lock_id} < LOCKS_LIM;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // classify: unknown functions and out-of-range ids (except on create) go straight to the error path
   always_comb begin
      q_item.role = req_role;
      q_item.idx  = id_ok ? req_lock_id : 8'd0;
      case (req_func)
         FN_CREATE: begin
            q_item.op = OP_CREATE;
         end
         FN_ACQUIRE: begin
            q_item.op = id_ok ? OP_ACQUIRE : OP_BAD;
         end
         FN_RELEASE: begin
            q_item.op = id_ok ? OP_RELEASE : OP_BAD;
         end
         FN_DESTROY: begin
            q_item.op = id_ok ? OP_DESTROY : OP_BAD;
         end
         FN_POLL: begin
            q_item.op = id_ok ? OP_POLL : OP_BAD;
         end
         default: begin
            q_item.op = OP_BAD;
         end
      endcase
   end

endmodule

// ----- src/tplt_queue.sv -----
module tplt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tplt_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output tplt_pkg::item_type pop_item,
   output logic               empty
);
   import tplt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/tplt_back.sv -----
module tplt_back #(
   parameter int NUM_LOCKS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  tplt_pkg::item_type        q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic [5:0]                rsp_lock_index,
   output tplt_pkg::back_status_type back_status
);
   import tplt_pkg::*;

   localparam int IDX_W  = $clog2(NUM_LOCKS);
   localparam int NG     = (NUM_LOCKS + GRP_SIZE - 1) / GRP_SIZE;
   localparam int FULL_W = $clog2(NG * GRP_SIZE);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   item_type             item_ff;
   logic [NUM_LOCKS-1:0] in_use_ff, in_use_in;
   logic [2:0]           lock_mem [NUM_LOCKS];
   logic [2:0]           rd_ff;
   logic                 mem_we;
   logic [2:0]           mem_wdata;
   logic [IDX_W-1:0]     raddr, waddr, eidx;

   logic [NG*GRP_SIZE-1:0] used_pad;
   logic [NG-1:0]          grp_free_ff, grp_free_in;
   logic [GRP_W-1:0]       grp_low_ff [NG];
   logic [GRP_W-1:0]       grp_low_in [NG];
   logic                   found;
   logic [FULL_W-1:0]      fidx;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [5:0] rsp_index_ff, rsp_index_in;

   logic [1:0] want;
   logic       turn, mine, other, used;

   // pad the table to whole groups with entries that read as taken
   for (genvar i = 0; i < NG * GRP_SIZE; i++) begin : g_pad
      if (i < NUM_LOCKS) begin : g_real
         assign used_pad[i] = in_use_ff[i];
      end else begin : g_fill
         assign used_pad[i] = 1'b1;
      end
   end

   // first level of the free-slot search: lowest free entry within each group
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_free_in[g] = ~&used_pad[g*GRP_SIZE +: GRP_SIZE];
         grp_low_in[g]  = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (!used_pad[g*GRP_SIZE + b]) begin
               grp_low_in[g] = GRP_W'(b);
            end
         end
      end
   end

   // second level: lowest group with a free entry
   always_comb begin
      found = 1'b0;
      fidx  = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            found = 1'b1;
            fidx  = FULL_W'(g * GRP_SIZE + int'(grp_low_ff[g]));
         end
      end
   end

   assign q_pop = (state_ff == S_IDLE) && !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign raddr = q_item.idx[IDX_W-1:0];
   assign eidx  = item_ff.idx[IDX_W-1:0];

   assign want  = rd_ff[1:0];
   assign turn  = rd_ff[2];
   assign mine  = want[item_ff.role];
   assign other = want[~item_ff.role];
   assign used  = in_use_ff[eidx];

   always_comb begin
      state_in      = state_ff;
      in_use_in     = in_use_ff;
      mem_we        = 1'b0;
      mem_wdata     = rd_ff;
      waddr         = eidx;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_index_in  = '0;
            if (item_ff.op == OP_CREATE) begin
               if (found) begin
                  waddr            = fidx[IDX_W-1:0];
                  in_use_in[waddr] = 1'b1;
                  mem_we           = 1'b1;
                  mem_wdata        = 3'b000;
                  rsp_index_in     = 6'(fidx[IDX_W-1:0]);
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end else if (item_ff.op == OP_BAD || !used) begin
               rsp_status_in = ST_INVALID;
            end else begin
               case (item_ff.op)
                  OP_ACQUIRE: begin
                     if (mine) begin
                        rsp_status_in = ST_HELD;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {item_ff.role, want | (2'b01 << item_ff.role)};
                        if (other) begin
                           rsp_status_in = ST_WAIT;
                        end
                     end
                  end
                  OP_RELEASE: begin
                     if (!mine) begin
                        rsp_status_in = ST_NOT_HELD;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {turn, want & ~(2'b01 << item_ff.role)};
                     end
                  end
                  OP_DESTROY: begin
                     in_use_in[eidx] = 1'b0;
                  end
                  OP_POLL: begin
                     if (!mine) begin
                        rsp_status_in = ST_NOT_HELD;
                     end else if (other && turn == item_ff.role) begin
                        rsp_status_in = ST_WAIT;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_INVALID;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      if (q_pop) begin
         item_ff     <= q_item;
         grp_free_ff <= grp_free_in;
         grp_low_ff  <= grp_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lock_mem[waddr] <= mem_wdata;
      end
      if (q_pop) begin
         rd_ff <= lock_mem[raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_lock_index   = rsp_index_ff;
   assign back_status.idle = state_ff == S_IDLE;
   assign back_status.exec = state_ff == S_EXEC;

endmodule
